[sv/bbo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbo_pkg
// Shared types and constants of the bounding box border overlay.
// ----------------------------------------------------------------------------
package bbo_pkg;

   localparam int MAX_BOXES = 16;
   localparam int BOX_CNT_W = $clog2(MAX_BOXES + 1);
   localparam int BOX_IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   localparam int COORD_W = 13;
   localparam int PIX_W   = 12;
   localparam int COLOR_W = 8;
   localparam int THICK_W = 4;
   localparam int FRAME_W = 13;
   localparam int DIFF_W  = COORD_W + 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 24;

   localparam logic [THICK_W-1:0] THICK_RESET  = 4'd2;
   localparam logic [COLOR_W-1:0] RED_RESET    = 8'd0;
   localparam logic [COLOR_W-1:0] GREEN_RESET  = 8'd255;
   localparam logic [COLOR_W-1:0] BLUE_RESET   = 8'd0;
   localparam logic [FRAME_W-1:0] WIDTH_RESET  = 13'd1920;
   localparam logic [FRAME_W-1:0] HEIGHT_RESET = 13'd1080;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_THICKNESS = 3'd0,
      REG_RED       = 3'd1,
      REG_GREEN     = 3'd2,
      REG_BLUE      = 3'd3,
      REG_WIDTH     = 3'd4,
      REG_HEIGHT    = 3'd5
   } reg_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } box_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [THICK_W-1:0] thickness;
      rgb_type            color;
      logic [FRAME_W-1:0] frame_width;
      logic [FRAME_W-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [MAX_BOXES-1:0] hits;
      rgb_type              pixel;
   } job_type;

endpackage

[sv/bbo_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbo_csr
// Configuration registers behind an APB-style write and read port.
// ----------------------------------------------------------------------------
module bbo_csr
   import bbo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_THICKNESS: cfg_in.thickness    = csr_pwdata[THICK_W-1:0];
            REG_RED:       cfg_in.color.red    = csr_pwdata[COLOR_W-1:0];
            REG_GREEN:     cfg_in.color.green  = csr_pwdata[COLOR_W-1:0];
            REG_BLUE:      cfg_in.color.blue   = csr_pwdata[COLOR_W-1:0];
            REG_WIDTH:     cfg_in.frame_width  = csr_pwdata[FRAME_W-1:0];
            REG_HEIGHT:    cfg_in.frame_height = csr_pwdata[FRAME_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_THICKNESS: csr_prdata = CSR_DATA_W'(cfg_ff.thickness);
         REG_RED:       csr_prdata = CSR_DATA_W'(cfg_ff.color.red);
         REG_GREEN:     csr_prdata = CSR_DATA_W'(cfg_ff.color.green);
         REG_BLUE:      csr_prdata = CSR_DATA_W'(cfg_ff.color.blue);
         REG_WIDTH:     csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_HEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thickness    <= THICK_RESET;
         cfg_ff.color.red    <= RED_RESET;
         cfg_ff.color.green  <= GREEN_RESET;
         cfg_ff.color.blue   <= BLUE_RESET;
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/bbo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbo_front
// Accepts commands, keeps the box table and tests each pixel against every
// stored box in parallel lanes, pushing one job per pixel.
// ----------------------------------------------------------------------------
module bbo_front
   import bbo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  cmd_type    req_cmd,
   input  box_type    req_box,
   input  logic [PIX_W-1:0] req_x,
   input  logic [PIX_W-1:0] req_y,
   input  rgb_type    req_pixel,
   input  logic       job_full,
   output logic       job_push,
   output job_type    job
);

   box_type              table_ff [MAX_BOXES];
   logic [BOX_CNT_W-1:0] count_ff, count_in;
   logic                 accept;
   logic                 load_en;
   logic                 in_frame;
   logic [MAX_BOXES-1:0] hits;

   function automatic logic box_hit(box_type b, logic [PIX_W-1:0] x,
                                    logic [PIX_W-1:0] y, logic [THICK_W-1:0] t);
      logic signed [DIFF_W-1:0] xs, ys, ts;
      logic signed [DIFF_W-1:0] dl, dt, dr, db;
      logic                     in_box;
      xs = $signed({{(DIFF_W-PIX_W){1'b0}}, x});
      ys = $signed({{(DIFF_W-PIX_W){1'b0}}, y});
      ts = $signed({{(DIFF_W-THICK_W){1'b0}}, t});
      dl = xs - DIFF_W'(b.left);
      dt = ys - DIFF_W'(b.top);
      dr = DIFF_W'(b.right) - xs;
      db = DIFF_W'(b.bottom) - ys;
      in_box = !dl[DIFF_W-1] && !dt[DIFF_W-1] && !dr[DIFF_W-1] && !db[DIFF_W-1];
      return in_box && ((dl < ts) || (dt < ts) || (dr < ts) || (db < ts));
   endfunction

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign load_en   = accept && (req_cmd == CMD_LOAD) &&
                      (count_ff < BOX_CNT_W'(MAX_BOXES));
   assign in_frame  = ({1'b0, req_x} < cfg.frame_width) &&
                      ({1'b0, req_y} < cfg.frame_height);

   always_comb begin
      for (int i = 0; i < MAX_BOXES; i++) begin
         hits[i] = in_frame && (BOX_CNT_W'(i) < count_ff) &&
                   box_hit(table_ff[i], req_x, req_y, cfg.thickness);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && (req_cmd == CMD_CLEAR)) begin
         count_in = '0;
      end else if (load_en) begin
         count_in = count_ff + BOX_CNT_W'(1);
      end
   end

   assign job_push  = accept && (req_cmd == CMD_PIXEL);
   assign job.hits  = hits;
   assign job.pixel = req_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         table_ff[count_ff[BOX_IDX_W-1:0]] <= req_box;
      end
   end

endmodule

[sv/bbo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbo_queue
// Two-entry job queue between the classify and the drawing side.
// ----------------------------------------------------------------------------
module bbo_queue
   import bbo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/bbo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbo_back
// Merges the per-box hits of a job and drives the registered result.
// ----------------------------------------------------------------------------
module bbo_back
   import bbo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rgb_type rsp_color,
   output logic    rsp_border
);

   logic    valid_ff, valid_in;
   rgb_type color_ff, color_in;
   logic    border_ff, border_in;
   logic    load;
   logic    hit;

   assign load    = !valid_ff || rsp_ready;
   assign job_pop = load && job_valid;
   assign hit     = |job.hits;

   always_comb begin
      valid_in  = valid_ff;
      color_in  = color_ff;
      border_in = border_ff;
      if (load) begin
         valid_in  = job_valid;
         color_in  = hit ? cfg.color : job.pixel;
         border_in = hit;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_color  = color_ff;
   assign rsp_border = border_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff  <= color_in;
      border_ff <= border_in;
   end

endmodule

[sv/bounding_box_border_overlay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_border_overlay
// an accepted pixel is stored in the job queue, then in the rsp output register
// throughput: one transaction per cycle (box compare lanes) if queue has room
// clear and load transactions give no result and take effect for the next pixel
// reset: box count cleared, registers to defaults, box table contents undefined
// ----------------------------------------------------------------------------
module bounding_box_border_overlay
   import bbo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // box_left, box_top, box_right, box_bottom, pixel_x, pixel_y,
   // pixel_red, pixel_green, pixel_blue, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_red, out_green, out_blue
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // on_border
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type          cfg;
   box_type          req_box;
   rgb_type          req_pixel;
   logic [PIX_W-1:0] req_x, req_y;
   job_type          push_job, pop_job;
   logic             job_push, job_full, job_pop, job_valid;
   rgb_type          rsp_color;

   assign req_box.left    = req_tdata[12:0];
   assign req_box.top     = req_tdata[25:13];
   assign req_box.right   = req_tdata[38:26];
   assign req_box.bottom  = req_tdata[51:39];
   assign req_x           = req_tdata[63:52];
   assign req_y           = req_tdata[75:64];
   assign req_pixel.red   = req_tdata[83:76];
   assign req_pixel.green = req_tdata[91:84];
   assign req_pixel.blue  = req_tdata[99:92];

   assign rsp_tdata = {rsp_color.blue, rsp_color.green, rsp_color.red};

   bbo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (cmd_type'(req_tuser)),
      .req_box   (req_box),
      .req_x     (req_x),
      .req_y     (req_y),
      .req_pixel (req_pixel),
      .job_full  (job_full),
      .job_push  (job_push),
      .job       (push_job)
   );

   bbo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (pop_job)
   );

   bbo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .job_valid  (job_valid),
      .job        (pop_job),
      .job_pop    (job_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_color  (rsp_color),
      .rsp_border (rsp_tuser)
   );

endmodule
